// ===== rtl/selectable_bandpass_filter_assert.svh =====
// Assertion macros for the selectable band-pass filter.
// Included by the top level; no other dependencies.
`ifndef SELECTABLE_BANDPASS_FILTER_ASSERT_SVH
`define SELECTABLE_BANDPASS_FILTER_ASSERT_SVH
`ifndef SYNTH
`define SBF_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SBF_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SBF_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/sbf_pkg.sv =====
// Package for the selectable band-pass filter: mode codes, widths and coefficient tables.
// No dependencies.
`default_nettype none
package sbf_pkg;
  localparam int FIR_TAPS_DEF    = 64;
  localparam int IIR_ORDER_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OUT_BITS        = 19;
  localparam int HIST_BITS       = 48;
  localparam int COEF_BITS       = 16;
  localparam int ACC_BITS        = 64;

  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_IIR    = 2'd1;
  localparam logic [1:0] MODE_FIR    = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic signed [COEF_BITS-1:0] fir_coef(input logic [5:0] idx);
    logic signed [COEF_BITS-1:0] c;
    unique case (idx)
      6'd0: c = 16'sd4354;   6'd1: c = 16'sd3860;   6'd2: c = 16'sd2932;
      6'd3: c = 16'sd1679;   6'd4: c = 16'sd277;    6'd5: c = -16'sd1056;
      6'd6: c = -16'sd2106;  6'd7: c = -16'sd2700;  6'd8: c = -16'sd2742;
      6'd9: c = -16'sd2249;  6'd10: c = -16'sd1354; 6'd11: c = -16'sd296;
      6'd12: c = 16'sd612;   6'd13: c = 16'sd1039;  6'd14: c = 16'sd696;
      6'd15: c = -16'sd600;  6'd16: c = -16'sd2875; 6'd17: c = -16'sd5968;
      6'd18: c = -16'sd9529; 6'd19: c = -16'sd13051; 6'd20: c = -16'sd15939;
      6'd21: c = -16'sd17592; 6'd22: c = -16'sd17507; 6'd23: c = -16'sd15366;
      6'd24: c = -16'sd11115; 6'd25: c = -16'sd5000; 6'd26: c = 16'sd2440;
      6'd27: c = 16'sd10428; 6'd28: c = 16'sd18039; 6'd29: c = 16'sd24337;
      6'd30: c = 16'sd28511; 6'd31: c = 16'sd30054; 6'd32: c = 16'sd28511;
      6'd33: c = 16'sd24337; 6'd34: c = 16'sd18039; 6'd35: c = 16'sd10428;
      6'd36: c = 16'sd2440;  6'd37: c = -16'sd5000; 6'd38: c = -16'sd11115;
      6'd39: c = -16'sd15366; 6'd40: c = -16'sd17507; 6'd41: c = -16'sd17592;
      6'd42: c = -16'sd15939; 6'd43: c = -16'sd13051; 6'd44: c = -16'sd9529;
      6'd45: c = -16'sd5968; 6'd46: c = -16'sd2875; 6'd47: c = -16'sd600;
      6'd48: c = 16'sd696;   6'd49: c = 16'sd1039;  6'd50: c = 16'sd612;
      6'd51: c = -16'sd296;  6'd52: c = -16'sd1354; 6'd53: c = -16'sd2249;
      6'd54: c = -16'sd2742; 6'd55: c = -16'sd2700; 6'd56: c = -16'sd2106;
      6'd57: c = -16'sd1056; 6'd58: c = 16'sd277;   6'd59: c = 16'sd1679;
      6'd60: c = 16'sd2932;  6'd61: c = 16'sd3860;  6'd62: c = 16'sd4354;
      6'd63: c = 16'sd4383;
      default: c = '0;
    endcase
    return c;
  endfunction

  // IIR: step k in 0..8. Step 0 is b0*x0. The histories are read oldest first, so
  // odd steps take b4..b1 against x[3]..x[0] and even steps -a4..-a1 against y[3]..y[0].
  function automatic logic signed [COEF_BITS-1:0] iir_coef(input logic [3:0] k);
    logic signed [COEF_BITS-1:0] c;
    unique case (k)
      4'd0: c = 16'sd10231;
      4'd1: c = 16'sd10231;  4'd2: c = -16'sd2737;
      4'd3: c = 16'sd0;      4'd4: c = 16'sd11666;
      4'd5: c = -16'sd20462; 4'd6: c = -16'sd19145;
      4'd7: c = 16'sd0;      4'd8: c = 16'sd14300;
      default: c = '0;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/selectable_bandpass_filter.sv =====
// Selectable band-pass filter, top level: control sequencer, MAC unit and sample rings.
// Depends on sbf_pkg, sbf_ring, sbf_cell and selectable_bandpass_filter_assert.svh.
//
// One sample in, one filtered sample out. Bypass saturates the input into the
// result register; the IIR path runs its MAC steps, then ST_DIV and ST_OUT to
// scale, and the FIR path one multiply-accumulate per tap, then ST_DIV: all on
// a single 16x48 MAC fed by rings of delay cells that rotate one position at a time.
// The next sample is taken once the result register is free again; mode 3 is bypass.
`default_nettype none
module selectable_bandpass_filter import sbf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_filter_mode,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [OUT_BITS-1:0]         out_filtered
);
  `include "selectable_bandpass_filter_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIR  = 3'd1;
  localparam logic [2:0] ST_IIR  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [1:0] mode_r;
  logic [2:0] st_r, st_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic signed [ACC_BITS-1:0] acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [OUT_BITS-1:0] res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [HIST_BITS-1:0] y0_r, y0_nxt;
  logic accept;

  // FIR ring: 63 cells holding the delay line; a sweep rotates it once all the
  // way round, then the scaling step loads the new sample and drops the oldest.
  cell_ctl_t fir_ctl, xin_ctl, yout_ctl;
  logic fir_load, xin_load, yout_load;
  logic [SAMPLE_BITS-1:0] fir_tail, xin_tail;
  logic [HIST_BITS-1:0] yout_tail;

  sbf_ring #(.W(SAMPLE_BITS), .N(FIR_TAPS_DEF - 1)) u_fir (
    .clk(clk), .rst_n(rst_n), .ctl(fir_ctl), .load(fir_load),
    .new_val(x_r), .tail(fir_tail));
  sbf_ring #(.W(SAMPLE_BITS), .N(IIR_ORDER_DEF)) u_xin (
    .clk(clk), .rst_n(rst_n), .ctl(xin_ctl), .load(xin_load),
    .new_val(x_r), .tail(xin_tail));
  sbf_ring #(.W(HIST_BITS), .N(IIR_ORDER_DEF)) u_yout (
    .clk(clk), .rst_n(rst_n), .ctl(yout_ctl), .load(yout_load),
    .new_val(y0_r), .tail(yout_tail));

  assign accept   = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE) && !out_valid_r;

  logic signed [COEF_BITS-1:0] coef;
  logic signed [HIST_BITS-1:0] opnd;
  logic signed [ACC_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0] q12;
  logic signed [HIST_BITS-1:0] y_div;

  // Step 0 of the FIR sweep multiplies the new sample by coef[0]. Steps 1..63
  // read the ring tail, oldest delay first, against coef[64-c].
  always_comb begin
    coef = '0;
    opnd = '0;
    if (st_r == ST_FIR) begin
      coef = fir_coef(6'(6'd0 - cnt_r));
      if (cnt_r == 6'd0) opnd = HIST_BITS'(x_r);
      else opnd = HIST_BITS'(signed'(fir_tail));
    end else if (st_r == ST_IIR) begin
      coef = iir_coef(cnt_r[3:0]);
      if (cnt_r == 6'd0) opnd = HIST_BITS'(x_r);
      else if (cnt_r[0]) opnd = HIST_BITS'(signed'(xin_tail));
      else opnd = signed'(yout_tail);
    end
  end
  assign prod = ACC_BITS'(coef) * ACC_BITS'(opnd);

  always_comb begin
    q12   = (acc_r + (acc_r[ACC_BITS-1] ? ACC_BITS'(64'sd4095) : ACC_BITS'(64'sd0))) >>> 12;
    y_div = HIST_BITS'(q12);
  end

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [ACC_BITS-1:0] v);
    if (v > ACC_BITS'(64'sd262143)) return OUT_BITS'(19'sd262143);
    if (v < -ACC_BITS'(64'sd262144)) return OUT_BITS'(-64'sd262144);
    return OUT_BITS'(v);
  endfunction

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; acc_nxt = acc_r; res_nxt = res_r;
    y0_nxt = y0_r; out_valid_nxt = out_valid_r;
    fir_ctl = '0; xin_ctl = '0; yout_ctl = '0;
    fir_load = 1'b0; xin_load = 1'b0; yout_load = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (mode_r == MODE_IIR) st_nxt = ST_IIR;
          else if (mode_r == MODE_FIR) st_nxt = ST_FIR;
          else begin
            res_nxt = sat(ACC_BITS'(in_sample));
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_FIR: begin
        // The ring rotates on steps 1..63 only, which brings it back in place.
        acc_nxt = acc_r + prod;
        fir_ctl.shift = (cnt_r != 6'd0);
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) st_nxt = ST_DIV;
      end
      ST_IIR: begin
        acc_nxt = acc_r + prod;
        if (cnt_r != 6'd0) begin
          if (cnt_r[0]) xin_ctl.shift = 1'b1;
          else yout_ctl.shift = 1'b1;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (mode_r == MODE_IIR) begin
          y0_nxt = y_div;
          st_nxt = ST_OUT;
        end else begin
          // Push the new sample into the delay line; the oldest drops out.
          fir_ctl.shift = 1'b1; fir_load = 1'b1;
          res_nxt = sat((acc_r + (acc_r[ACC_BITS-1] ? ACC_BITS'(64'sd262143)
                                                    : ACC_BITS'(64'sd0))) >>> 18);
          out_valid_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        // Push the new input and output into the histories; oldest drops out.
        xin_ctl.shift = 1'b1; xin_load = 1'b1;
        yout_ctl.shift = 1'b1; yout_load = 1'b1;
        res_nxt = sat(ACC_BITS'((y0_r + (y0_r[HIST_BITS-1] ? HIST_BITS'(127)
                                                           : HIST_BITS'(0))) >>> 7));
        out_valid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BYPASS;
      st_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_filter_mode;
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    y0_r  <= y0_nxt;
    if (accept) x_r <= in_sample;
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = res_r;

  `SBF_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (st_r != ST_IDLE) |-> !in_ready, "busy accept")
  `SBF_ASSERT_IMPL(a_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_filtered), "hold")
  `SBF_ASSERT_NEVER(a_cnt, clk, rst_n, (st_r == ST_IIR) && (cnt_r > 6'd8), "iir count")
endmodule
`default_nettype wire

// ===== rtl/sbf_cell.sv =====
// One delay cell of the sample chain: holds one value and hands it to its neighbor.
// Depends on sbf_pkg.
`default_nettype none
module sbf_cell import sbf_pkg::*; #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cell_ctl_t    ctl,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);
  logic [W-1:0] q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (ctl.clear) begin
      q_r <= '0;
    end else if (ctl.shift) begin
      q_r <= d;
    end
  end
  assign q = q_r;
endmodule
`default_nettype wire

// ===== rtl/sbf_ring.sv =====
// A ring of delay cells. Shifting by one rotates the ring; a load step
// puts a new value in the head while the oldest drops out.
// Depends on sbf_pkg and sbf_cell.
`default_nettype none
module sbf_ring import sbf_pkg::*; #(
  parameter int W = 16,
  parameter int N = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cell_ctl_t    ctl,
  input  wire logic         load,
  input  wire logic [W-1:0] new_val,
  output logic [W-1:0]      tail
);
  logic [W-1:0] q [N];
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] d;
    if (i == 0) begin : g_head
      assign d = load ? new_val : q[N-1];
    end else begin : g_body
      assign d = q[i-1];
    end
    sbf_cell #(.W(W)) u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .d(d), .q(q[i]));
  end
  assign tail = q[N-1];
endmodule
`default_nettype wire
